@@ design/nfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// nfsp_pkg: shared types and constants of the negatives-first list reorder
// Store size, word widths, controller states and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nfsp_pkg;

    // Store size and derived widths
    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int WORD_W  = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;

    // Controller states
    typedef enum logic [2:0] {
        S_LOAD,     // take list elements
        S_NSCAN,    // scan the store for the largest unused negative
        S_NOUT,     // hand the found negative to the output register
        S_PRD,      // read the next element in arrival order
        S_PCHK,     // emit it if non-negative
        S_DONE      // clear the list state
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the input element or flag a drop
        logic scan_start;  // rewind the scan index and forget the best
        logic scan_step;   // issue one scan read and judge the returned one
        logic emit_best;   // send the best negative, mark it used
        logic rd_issue;    // read the element at the scan index
        logic emit_rd;     // send the element just read
        logic clear;       // drop the list, ready for the next one
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;   // all entries judged
        logic found;       // an unused negative was found
        logic rd_neg;      // element just read is negative
        logic idx_end;     // scan index reached the element count
        logic out_free;    // output register can take an item this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/nfsp_if.sv @@
// ----------------------------------------------------------------------------
// nfsp_if: item channels of the list reorder block
// One interface for the input elements and one for the reordered results,
// each with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nfsp_in_if;
    logic              valid;
    logic              ready;
    nfsp_pkg::t_word   value;
    logic              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface nfsp_out_if;
    logic              valid;
    logic              ready;
    nfsp_pkg::t_word   result_value;
    logic              result_last;
    logic              overflow;

    modport source (output valid, output result_value, output result_last,
                    output overflow, input ready);
    modport sink   (input valid, input result_value, input result_last,
                    input overflow, output ready);
endinterface

`default_nettype wire

@@ design/nfsp_dp.sv @@
// ----------------------------------------------------------------------------
// nfsp_dp: datapath of the list reorder block
// Element memory, count and drop flag, used marks, scan index with the
// best-negative tracker, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfsp_dp (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire nfsp_pkg::t_dp_cmd    i_cmd,
    output nfsp_pkg::t_dp_stat        o_stat,
    input  wire nfsp_pkg::t_word      i_value,
    input  wire                       i_out_ready,
    output logic                      o_out_valid,
    output nfsp_pkg::t_word           o_result_value,
    output logic                      o_result_last,
    output logic                      o_overflow
);
    import nfsp_pkg::*;

    t_word               mem [MAX_LEN];

    t_cnt                r_count;
    logic                r_drop;
    logic [MAX_LEN-1:0]  r_used;
    t_cnt                r_emit_cnt;
    t_cnt                r_idx;
    t_word               r_rd;
    t_addr               r_rd_idx;
    logic                r_rd_vld;
    t_word               r_best;
    t_addr               r_best_idx;
    logic                r_found;
    logic                r_out_valid;
    t_word               r_out_value;
    logic                r_out_last;
    logic                r_out_ovf;

    logic                idx_end;
    logic                rd_en;
    logic                cand;
    logic                emit;
    logic                emit_last;
    t_word               emit_value;

    // Scan bookkeeping
    assign idx_end   = (r_idx == r_count);
    assign rd_en     = (i_cmd.scan_step && !idx_end) || i_cmd.rd_issue;
    assign cand      = i_cmd.scan_step && r_rd_vld && r_rd[WORD_W-1]
                       && !r_used[r_rd_idx] && (!r_found || (r_rd > r_best));
    assign emit      = i_cmd.emit_best || i_cmd.emit_rd;
    assign emit_last = ((r_emit_cnt + t_cnt'(1)) == r_count);
    assign emit_value = i_cmd.emit_best ? r_best : r_rd;

    assign o_stat.scan_done = !r_rd_vld && idx_end;
    assign o_stat.found     = r_found;
    assign o_stat.rd_neg    = r_rd[WORD_W-1];
    assign o_stat.idx_end   = idx_end;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Element memory: write on load, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < t_cnt'(MAX_LEN))) begin
            mem[r_count[ADDR_W-1:0]] <= i_value;
        end
        if (rd_en) begin
            r_rd <= mem[r_idx[ADDR_W-1:0]];
        end
    end

    // Payload registers of the scan and the output
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= r_idx[ADDR_W-1:0];
        end
        if (cand) begin
            r_best     <= r_rd;
            r_best_idx <= r_rd_idx;
        end
        if (emit) begin
            r_out_value <= emit_value;
            r_out_last  <= emit_last;
            r_out_ovf   <= r_drop;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_used      <= '0;
            r_emit_cnt  <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // count the stored element, or flag a drop once full
            if (i_cmd.load) begin
                if (r_count < t_cnt'(MAX_LEN)) begin
                    r_count <= r_count + t_cnt'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end

            // advance the scan
            if (i_cmd.scan_start) begin
                r_idx    <= '0;
                r_found  <= 1'b0;
                r_rd_vld <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_idx <= r_idx + t_cnt'(1);
                end
                if (i_cmd.scan_step) begin
                    r_rd_vld <= rd_en;
                end
                if (cand) begin
                    r_found <= 1'b1;
                end
            end

            // mark sent negatives and count results
            if (i_cmd.emit_best) begin
                r_used[r_best_idx] <= 1'b1;
            end
            if (emit) begin
                r_emit_cnt <= r_emit_cnt + t_cnt'(1);
            end

            // output register
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // drop the finished list
            if (i_cmd.clear) begin
                r_count    <= '0;
                r_drop     <= 1'b0;
                r_used     <= '0;
                r_emit_cnt <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_last  = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

`default_nettype wire

@@ design/nfsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// nfsp_ctrl: controller of the list reorder block
// Sequences loading, the repeated scans for the largest unused negative,
// the in-order pass over the non-negatives, and the list clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfsp_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_in_last,
    output logic                      o_in_ready,
    input  wire nfsp_pkg::t_dp_stat   i_stat,
    output nfsp_pkg::t_dp_cmd         o_cmd
);
    import nfsp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_in_last) n_state = S_NSCAN;
            end
            S_NSCAN: begin
                if (i_stat.scan_done) begin
                    n_state = i_stat.found ? S_NOUT : S_PRD;
                end
            end
            S_NOUT: begin
                if (i_stat.out_free) n_state = S_NSCAN;
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_stat.rd_neg || i_stat.out_free) begin
                    n_state = i_stat.idx_end ? S_DONE : S_PRD;
                end
            end
            S_DONE: begin
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready       = 1'b1;
                o_cmd.load       = i_in_valid;
                o_cmd.scan_start = i_in_valid && i_in_last;
            end
            S_NSCAN: begin
                o_cmd.scan_step  = !i_stat.scan_done;
                o_cmd.scan_start = i_stat.scan_done && !i_stat.found;
            end
            S_NOUT: begin
                o_cmd.emit_best  = i_stat.out_free;
                o_cmd.scan_start = i_stat.out_free;
            end
            S_PRD: begin
                o_cmd.rd_issue = 1'b1;
            end
            S_PCHK: begin
                o_cmd.emit_rd = !i_stat.rd_neg && i_stat.out_free;
            end
            S_DONE: begin
                o_cmd.clear = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/negatives_first_sorted_partition.sv @@
// ----------------------------------------------------------------------------
// negatives_first_sorted_partition: list reorder block
// Stores a list of signed words and sends it back with the negatives first,
// in descending order, followed by the non-negatives in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one list element per item, with last on the final one.
//   Up to 64 elements are stored; later ones are dropped and every result
//   of that list then carries overflow. The item marked last ends the list
//   even when it is dropped itself.
//   Loading takes one item per cycle. After the last item the block emits
//   the n stored elements on o_out, result_last on the final one. Each
//   negative result costs one scan of the store through its single read
//   port plus the hand-off to the output register; each non-negative
//   is read and then checked before it follows in arrival order.
//   i_in is not ready while a list is being sent; the next list may start
//   loading while the final result still sits in the output register.
//   A stalled receiver holds the output register and pauses the sequence.
//   After reset the store is empty and the block takes items at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module negatives_first_sorted_partition (
    input  wire         i_clk,
    input  wire         i_rst_n,
    nfsp_in_if.sink     i_in,
    nfsp_out_if.source  o_out
);
    import nfsp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    nfsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Store, scan and output register
    nfsp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_value        (i_in.value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_result_last  (o_out.result_last),
        .o_overflow     (o_out.overflow)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the negatives-first list reorder block
// Sends lists of signed words, predicts the reordered output of each list
// (negatives descending, then non-negatives in arrival order, overflow when
// the store ran out of room) and checks every result field by field, under
// random idling on both channels in all but the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import nfsp_pkg::*;

    localparam int IDLE_LIMIT  = 5000;  // cycles with no item moving on either side
    localparam int DRAIN_WAIT  = 200;   // cycles to watch for stray results at the end
    localparam int PHASE_ITEMS = 30;    // least number of random items per idling phase

    typedef struct packed {
        t_word value;
        logic  last;
        logic  typed;       // expected result written out below
        t_word exp_value;   // single-element list comes back unchanged
    } t_dir_row;

    typedef struct {
        t_word value;
        logic  last;
        logic  ovf;
    } t_result;

    // Directed lists: extremes, mixed signs, equal negatives, zeros in order
    localparam int DIR_ROWS = 24;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
        '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff},
        '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
        '{32'shffff_ffff, 1'b1, 1'b1, 32'shffff_ffff},
        '{32'sd5,         1'b0, 1'b0, 32'sd0},
        '{-32'sd3,        1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b0, 1'b0, 32'sd0},
        '{-32'sd7,        1'b0, 1'b0, 32'sd0},
        '{-32'sd3,        1'b0, 1'b0, 32'sd0},
        '{32'sd2,         1'b0, 1'b0, 32'sd0},
        '{-32'sd1,        1'b1, 1'b0, 32'sd0},
        '{32'sh7fff_ffff, 1'b0, 1'b0, 32'sd0},
        '{32'sh8000_0000, 1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b0, 1'b0, 32'sd0},
        '{32'shffff_ffff, 1'b0, 1'b0, 32'sd0},
        '{32'sd1,         1'b1, 1'b0, 32'sd0},
        '{32'sd0,         1'b0, 1'b0, 32'sd0},
        '{32'sd3,         1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b0, 1'b0, 32'sd0},
        '{32'sd1,         1'b1, 1'b0, 32'sd0},
        '{-32'sd2,        1'b0, 1'b0, 32'sd0},
        '{-32'sd9,        1'b0, 1'b0, 32'sd0},
        '{-32'sd2,        1'b0, 1'b0, 32'sd0},
        '{-32'sd5,        1'b1, 1'b0, 32'sd0}
    };

    logic i_clk;
    logic i_rst_n;

    nfsp_in_if  in_ch ();
    nfsp_out_if out_ch ();

    negatives_first_sorted_partition i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // List being loaded, as the block should hold it
    t_word   held_words[$];
    logic    held_dropped;
    t_result expected_results[$];

    int sender_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int items_sent;
    int lists_sent;
    int overflow_lists;
    int results_checked;
    int quiet_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Store one element or flag a drop; on the last one, queue the reordered list
    function automatic void predict_item(t_word v, logic l, logic typed, t_word typed_v);
        t_word negs[$];
        int    pos;
        if (held_words.size() < MAX_LEN) begin
            held_words.push_back(v);
        end else begin
            held_dropped = 1'b1;
        end
        if (!l) return;
        lists_sent++;
        if (held_dropped) overflow_lists++;
        if (typed) begin
            expected_results.push_back('{typed_v, 1'b1, 1'b0});
        end else begin
            // negatives in descending order, then non-negatives as they came
            foreach (held_words[k]) begin
                if (held_words[k] < 0) begin
                    pos = 0;
                    while (pos < negs.size() && negs[pos] >= held_words[k]) pos++;
                    negs.insert(pos, held_words[k]);
                end
            end
            foreach (held_words[k]) begin
                if (held_words[k] >= 0) negs.push_back(held_words[k]);
            end
            foreach (negs[k]) begin
                expected_results.push_back('{negs[k], k == negs.size() - 1, held_dropped});
            end
        end
        held_words.delete();
        held_dropped = 1'b0;
    endfunction

    // Random word, biased toward extremes, small values and negatives
    function automatic t_word rand_word();
        case ($urandom_range(5))
            0:       return $urandom_range(16) - 8;
            1:       return $urandom | 32'h8000_0000;
            2: begin
                case ($urandom_range(3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Offer one item after a random gap, hold it until accepted
    task automatic send_item(t_word v, logic l, logic typed, t_word typed_v);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        predict_item(v, l, typed, typed_v);
    endtask

    task automatic send_list(int len);
        for (int k = 0; k < len; k++) begin
            send_item(rand_word(), k == len - 1, 1'b0, 32'sd0);
        end
    endtask

    // Receiver stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d last=%0b overflow=%0b", $time,
                         out_ch.result_value, out_ch.result_last, out_ch.overflow);
                mismatches++;
            end else begin
                if (out_ch.result_value !== expected_results[0].value) begin
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             expected_results[0].value, out_ch.result_value);
                    mismatches++;
                end
                if (out_ch.result_last !== expected_results[0].last) begin
                    $display("%0t: result_last expected %0b actual %0b", $time,
                             expected_results[0].last, out_ch.result_last);
                    mismatches++;
                end
                if (out_ch.overflow !== expected_results[0].ovf) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             expected_results[0].ovf, out_ch.overflow);
                    mismatches++;
                end
                void'(expected_results.pop_front());
                results_checked++;
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int phase_start;
        mismatches      = 0;
        items_sent      = 0;
        lists_sent      = 0;
        overflow_lists  = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        held_dropped    = 1'b0;
        sender_idle_pct = 25;
        recv_idle_pct   = 57;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.value     = '0;
        in_ch.last      = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lists
        foreach (DIR_TABLE[r]) begin
            send_item(DIR_TABLE[r].value, DIR_TABLE[r].last, DIR_TABLE[r].typed,
                      DIR_TABLE[r].exp_value);
        end

        // Random lists in three idling phases; the first opens with a long list
        // that fills the store exactly, then has two items dropped, the last one
        // among them
        for (int p = 0; p < 3; p++) begin
            if (p > 0) begin
                // hold the sender until the output side has caught up
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            case (p)
                0: begin
                    sender_idle_pct = 25;
                    recv_idle_pct   = 57;
                end
                1: begin
                    sender_idle_pct = 57;
                    recv_idle_pct   = 25;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 0;
                end
            endcase
            phase_start = items_sent;
            if (p == 0) begin
                send_list(MAX_LEN + 2);
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_list($urandom_range(8, 1));
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then watch for stray results
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d items in %0d lists, %0d of them over capacity;", items_sent,
                 lists_sent, overflow_lists);
        $display("checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/nfsp_pkg.sv
design/nfsp_if.sv
design/nfsp_dp.sv
design/nfsp_ctrl.sv
design/negatives_first_sorted_partition.sv
dv/testbench.sv
